@@ rtl/tod_pkg.sv @@
// Shared types and constants for the time-of-day counter with alarm.
`default_nettype none

package tod_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_HOUR    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_MINUTE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_MORNING = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_ENABLE  = 2'd3;

    localparam logic [1:0] MODE_TICK   = 2'd0;
    localparam logic [1:0] MODE_LOAD   = 2'd1;
    localparam logic [1:0] MODE_FORMAT = 2'd2;
    localparam logic [1:0] MODE_ACK    = 2'd3;

    localparam logic [4:0] HOUR_NOON      = 5'd12;
    localparam logic [4:0] HOUR_ONE       = 5'd1;
    localparam logic [4:0] HOUR_MIDNIGHT  = 5'd0;
    localparam logic [5:0] HOUR_WRAP_12   = 6'd13;
    localparam logic [5:0] HOUR_WRAP_24   = 6'd24;
    localparam logic [6:0] ENTRY_HOUR_12  = 7'd12;
    localparam logic [6:0] ENTRY_HOUR_24  = 7'd23;
    localparam logic [6:0] ENTRY_MS_MAX   = 7'd59;
    localparam logic [6:0] COUNT_LIMIT    = 7'd60;

    localparam logic [4:0] RST_HOUR          = 5'd12;
    localparam logic [4:0] RST_ALARM_HOUR    = 5'd12;
    localparam logic [5:0] RST_ALARM_MINUTE  = 6'd0;
    localparam logic       RST_ALARM_MORNING = 1'b1;
    localparam logic       RST_ALARM_ENABLE  = 1'b0;

    typedef struct packed {
        logic [1:0] mode;
        logic [6:0] hour_value;
        logic [6:0] minute_value;
        logic [6:0] second_value;
        logic       format_select;
        logic       morning_select;
    } tod_in_t;

    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic       morning;
        logic       twelve_hour;
        logic       alarm_ringing;
    } tod_out_t;

    typedef struct packed {
        logic [4:0] alarm_hour;
        logic [5:0] alarm_minute;
        logic       alarm_morning;
        logic       alarm_enable;
    } tod_cfg_t;

endpackage

`default_nettype wire

@@ rtl/time_of_day_counter_with_alarm_unit.sv @@
// Top level of the time-of-day counter with alarm: input stage and result handshake.
//
// Usage:
//   s_valid/s_ready/s_data carry one command per transaction: a one-second tick,
//   a time load, a 12/24-hour format change or an alarm acknowledge.
//   m_valid/m_ready/m_data return exactly one snapshot per command: hours,
//   minutes, seconds, AM flag, format and alarm latch after the update.
//   cfg_wr_en/cfg_index/cfg_wdata write the alarm hour, minute, AM flag and
//   enable; write them only while no command is in flight.
//   An accepted command is held in the input register until the result
//   channel is free, then the state register that doubles as result loads it.
//   Throughput: one command per cycle while m_ready stays high, set by the state update.
//   The state registers drive m_data directly, so they change only when a new
//   result is loaded; when m_ready is low the result holds and the input
//   register still takes one more command before s_ready drops.
//   Reset: 12:00:00 AM in twelve-hour format, latch clear, alarm 12:00 AM
//   disarmed, both channels empty.
`default_nettype none

module time_of_day_counter_with_alarm_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire tod_pkg::tod_in_t                s_data,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output tod_pkg::tod_out_t                    m_data,
    input  wire logic                            cfg_wr_en,
    input  wire logic [tod_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [tod_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import tod_pkg::*;

    logic     in_valid_reg, in_valid_next;
    tod_in_t  in_data_reg;
    logic     m_valid_reg, m_valid_next;
    logic     advance;
    tod_cfg_t cfg;

    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    tod_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    tod_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_data_reg),
        .cfg     (cfg),
        .state   (m_data)
    );

    assign m_valid = m_valid_reg;

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result changed while stalled");

    a_no_loss: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && m_valid && !m_ready) |=> in_valid_reg)
        else $error("pending transaction dropped");

    a_ready_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("input stage empty but not ready");

endmodule

`default_nettype wire

@@ rtl/tod_cfg.sv @@
// Alarm configuration registers written through the plain write port.
`default_nettype none

module tod_cfg (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [tod_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [tod_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output tod_pkg::tod_cfg_t                    cfg
);
    import tod_pkg::*;

    tod_cfg_t cfg_reg;
    tod_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_ALARM_HOUR:    cfg_next.alarm_hour    = cfg_wdata[4:0];
                CFG_ALARM_MINUTE:  cfg_next.alarm_minute  = cfg_wdata[5:0];
                CFG_ALARM_MORNING: cfg_next.alarm_morning = cfg_wdata[0];
                CFG_ALARM_ENABLE:  cfg_next.alarm_enable  = cfg_wdata[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.alarm_hour    <= RST_ALARM_HOUR;
            cfg_reg.alarm_minute  <= RST_ALARM_MINUTE;
            cfg_reg.alarm_morning <= RST_ALARM_MORNING;
            cfg_reg.alarm_enable  <= RST_ALARM_ENABLE;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ rtl/tod_core.sv @@
// Clock state registers and the single-pass update for one transaction.
`default_nettype none

module tod_core (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               advance,
    input  wire tod_pkg::tod_in_t   item,
    input  wire tod_pkg::tod_cfg_t  cfg,
    output tod_pkg::tod_out_t       state
);
    import tod_pkg::*;

    logic [4:0] hour_count_reg,   hour_count_next;
    logic [5:0] minute_count_reg, minute_count_next;
    logic [5:0] second_count_reg, second_count_next;
    logic       morning_flag_reg, morning_flag_next;
    logic       format_twelve_reg, format_twelve_next;
    logic       ringing_latch_reg, ringing_latch_next;

    logic [6:0] sec_inc;
    logic       sec_wrap;
    logic [5:0] sec_tick;
    logic [6:0] min_inc;
    logic       min_wrap;
    logic [5:0] min_tick;
    logic [5:0] hour_inc;
    logic [4:0] hour_tick;
    logic       zero_mark;
    logic       morning_tick;
    logic       ring_tick;

    logic [4:0] hour_load;
    logic [5:0] min_load;
    logic [5:0] sec_load;
    logic       morning_load;

    assign sec_inc  = {1'b0, second_count_reg} + 7'd1;
    assign sec_wrap = sec_inc >= COUNT_LIMIT;
    assign sec_tick = sec_wrap ? 6'd0 : sec_inc[5:0];
    assign min_inc  = {1'b0, minute_count_reg} + {6'd0, sec_wrap};
    assign min_wrap = min_inc >= COUNT_LIMIT;
    assign min_tick = min_wrap ? 6'd0 : min_inc[5:0];
    assign hour_inc = {1'b0, hour_count_reg} + {5'd0, min_wrap};
    assign zero_mark = (min_tick == 6'd0) && (sec_tick == 6'd0);

    always_comb begin
        if (format_twelve_reg) begin
            hour_tick    = (hour_inc >= HOUR_WRAP_12) ? HOUR_ONE : hour_inc[4:0];
            morning_tick = morning_flag_reg ^ ((hour_tick == HOUR_NOON) && zero_mark);
        end else begin
            hour_tick = (hour_inc >= HOUR_WRAP_24) ? HOUR_MIDNIGHT : hour_inc[4:0];
            if (hour_tick < HOUR_NOON) begin
                morning_tick = 1'b1;
            end else if (hour_tick > HOUR_NOON) begin
                morning_tick = 1'b0;
            end else if (zero_mark) begin
                morning_tick = 1'b0;
            end else begin
                morning_tick = morning_flag_reg;
            end
        end
    end

    assign ring_tick = ringing_latch_reg
                     | (cfg.alarm_enable
                        && (hour_tick == cfg.alarm_hour)
                        && (min_tick == cfg.alarm_minute)
                        && (sec_tick == 6'd0)
                        && (morning_tick == cfg.alarm_morning));

    always_comb begin
        if (item.format_select) begin
            if ((item.hour_value > ENTRY_HOUR_12) || (item.hour_value == 7'd0)) begin
                hour_load = HOUR_NOON;
            end else begin
                hour_load = item.hour_value[4:0];
            end
            morning_load = item.morning_select;
        end else begin
            if (item.hour_value > ENTRY_HOUR_24) begin
                hour_load = HOUR_MIDNIGHT;
            end else begin
                hour_load = item.hour_value[4:0];
            end
            morning_load = (hour_load == HOUR_NOON) ? 1'b0 : morning_flag_reg;
        end
    end

    assign min_load = (item.minute_value > ENTRY_MS_MAX) ? 6'd0 : item.minute_value[5:0];
    assign sec_load = (item.second_value > ENTRY_MS_MAX) ? 6'd0 : item.second_value[5:0];

    always_comb begin
        hour_count_next    = hour_count_reg;
        minute_count_next  = minute_count_reg;
        second_count_next  = second_count_reg;
        morning_flag_next  = morning_flag_reg;
        format_twelve_next = format_twelve_reg;
        ringing_latch_next = ringing_latch_reg;
        if (advance) begin
            case (item.mode)
                MODE_TICK: begin
                    hour_count_next    = hour_tick;
                    minute_count_next  = min_tick;
                    second_count_next  = sec_tick;
                    morning_flag_next  = morning_tick;
                    ringing_latch_next = ring_tick;
                end
                MODE_LOAD: begin
                    format_twelve_next = item.format_select;
                    hour_count_next    = hour_load;
                    minute_count_next  = min_load;
                    second_count_next  = sec_load;
                    morning_flag_next  = morning_load;
                end
                MODE_FORMAT: begin
                    if (item.format_select && !format_twelve_reg) begin
                        if (hour_count_reg > HOUR_NOON) begin
                            hour_count_next = hour_count_reg - HOUR_NOON;
                        end else if (hour_count_reg == HOUR_MIDNIGHT) begin
                            hour_count_next = HOUR_NOON;
                        end
                        format_twelve_next = 1'b1;
                    end else if (!item.format_select && format_twelve_reg) begin
                        if (hour_count_reg == HOUR_NOON) begin
                            if (morning_flag_reg) begin
                                hour_count_next = HOUR_MIDNIGHT;
                            end
                        end else if (!morning_flag_reg) begin
                            hour_count_next = hour_count_reg + HOUR_NOON;
                        end
                        format_twelve_next = 1'b0;
                    end
                end
                MODE_ACK: begin
                    ringing_latch_next = 1'b0;
                end
                default: begin
                    ringing_latch_next = ringing_latch_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hour_count_reg    <= RST_HOUR;
            minute_count_reg  <= 6'd0;
            second_count_reg  <= 6'd0;
            morning_flag_reg  <= 1'b1;
            format_twelve_reg <= 1'b1;
            ringing_latch_reg <= 1'b0;
        end else begin
            hour_count_reg    <= hour_count_next;
            minute_count_reg  <= minute_count_next;
            second_count_reg  <= second_count_next;
            morning_flag_reg  <= morning_flag_next;
            format_twelve_reg <= format_twelve_next;
            ringing_latch_reg <= ringing_latch_next;
        end
    end

    assign state.hours         = hour_count_reg;
    assign state.minutes       = minute_count_reg;
    assign state.seconds       = second_count_reg;
    assign state.morning       = morning_flag_reg;
    assign state.twelve_hour   = format_twelve_reg;
    assign state.alarm_ringing = ringing_latch_reg;

    a_ms_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (minute_count_reg <= 6'd59) && (second_count_reg <= 6'd59))
        else $error("minute or second count out of range");

    a_hour_range: assert property (@(posedge aclk) disable iff (!aresetn)
        format_twelve_reg ? ((hour_count_reg >= HOUR_ONE) && (hour_count_reg <= HOUR_NOON))
                          : (hour_count_reg <= 5'd23))
        else $error("hour count out of range for current format");

    a_ack_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (item.mode == MODE_ACK)) |=> !ringing_latch_reg)
        else $error("alarm acknowledge did not clear the latch");

    a_hold_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable({hour_count_reg, minute_count_reg, second_count_reg,
                              morning_flag_reg, format_twelve_reg, ringing_latch_reg}))
        else $error("clock state changed without a transaction");

endmodule

`default_nettype wire
